### src/rtlh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlh_pkg
// Shared types and constants of the round-trip latency histogram.
// ----------------------------------------------------------------------------
package rtlh_pkg;

	localparam int SLOTS    = 8;
	localparam int SLOT_AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NUM_W    = 10;
	localparam int TIME_W   = 32;
	localparam int OP_W     = 2;
	localparam int BKT_W    = 3;
	localparam int CNT_W    = 32;
	localparam int NBUCKETS = 6;
	localparam int NLIMITS  = NBUCKETS - 1;
	localparam int CFG_IW   = 3;
	localparam int CFG_DW   = 32;
	localparam int QDEPTH   = 2;
	localparam int Q_AW     = 1;
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	// Register indexes of the configuration port
	localparam logic [CFG_IW-1:0] CFG_LIMIT_FIRST  = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_LIMIT_SECOND = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_LIMIT_THIRD  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_LIMIT_FOURTH = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_LIMIT_FIFTH  = 3'd4;

	localparam logic [TIME_W-1:0] LIMIT_FIRST_RST  = 32'd15000;
	localparam logic [TIME_W-1:0] LIMIT_SECOND_RST = 32'd40000;
	localparam logic [TIME_W-1:0] LIMIT_THIRD_RST  = 32'd120000;
	localparam logic [TIME_W-1:0] LIMIT_FOURTH_RST = 32'd540000;
	localparam logic [TIME_W-1:0] LIMIT_FIFTH_RST  = 32'd1800000;

	localparam logic [BKT_W-1:0] LAST_BUCKET = BKT_W'(NBUCKETS - 1);

	typedef enum logic [OP_W-1:0] {
		OP_SENT = 2'd0,
		OP_ACK  = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} bk_state_t;

	typedef logic [NLIMITS-1:0][TIME_W-1:0] limits_t;

	// Classified command from front to back
	typedef struct packed {
		op_t               op;
		logic              matched;
		logic [TIME_W-1:0] elapsed;
	} cmd_t;

endpackage

### src/rtlh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlh_front
// Accepts events, matches them against the slot table and updates the table.
// ----------------------------------------------------------------------------
module rtlh_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rtlh_pkg::OP_W-1:0]    operation,
	input  logic [rtlh_pkg::NUM_W-1:0]   msg_number,
	input  logic [rtlh_pkg::TIME_W-1:0]  now_time,
	output rtlh_pkg::cmd_t               cmd,
	output logic                         cmd_valid,
	input  logic                         cmd_ready
);

	logic                          v_s1;
	logic [rtlh_pkg::OP_W-1:0]     op_s1;
	logic [rtlh_pkg::NUM_W-1:0]    num_s1;
	logic [rtlh_pkg::TIME_W-1:0]   now_s1;

	logic [rtlh_pkg::SLOTS-1:0]    slot_vld_q;
	logic [rtlh_pkg::NUM_W-1:0]    slot_num_q  [rtlh_pkg::SLOTS];
	logic [rtlh_pkg::TIME_W-1:0]   slot_time_q [rtlh_pkg::SLOTS];
	logic [rtlh_pkg::SLOT_AW-1:0]  next_q;
	logic [rtlh_pkg::SLOT_AW-1:0]  next_inc;

	logic [rtlh_pkg::SLOTS-1:0]    hit_vec;
	logic                          hit_any;
	logic [rtlh_pkg::SLOT_AW-1:0]  hit_idx;
	rtlh_pkg::op_t                 op;
	logic                          is_cmd;
	logic                          advance;
	logic                          take;

	// Parallel match, lowest index wins
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < rtlh_pkg::SLOTS; i++) begin
			hit_vec[i] = slot_vld_q[i] && (slot_num_q[i] == num_s1);
		end
		for (int i = rtlh_pkg::SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_any = 1'b1;
				hit_idx = rtlh_pkg::SLOT_AW'(i);
			end
		end
	end

	always_comb begin
		op = rtlh_pkg::op_t'(op_s1);
		unique case (op)
			rtlh_pkg::OP_SENT, rtlh_pkg::OP_ACK, rtlh_pkg::OP_READ: is_cmd = 1'b1;
			default: is_cmd = 1'b0;
		endcase
	end

	assign cmd_valid = v_s1 && is_cmd;
	assign advance   = v_s1 && (!is_cmd || cmd_ready);
	assign in_ready  = !v_s1 || advance;
	assign take      = in_valid && in_ready;
	assign next_inc  = (next_q == rtlh_pkg::SLOT_AW'(rtlh_pkg::SLOTS - 1)) ?
		'0 : next_q + 1'b1;

	always_comb begin
		cmd.op      = op;
		cmd.matched = hit_any && (op == rtlh_pkg::OP_SENT || op == rtlh_pkg::OP_ACK);
		cmd.elapsed = (hit_any && op == rtlh_pkg::OP_ACK) ?
			now_s1 - slot_time_q[hit_idx] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			slot_vld_q <= '0;
			next_q     <= '0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance && op == rtlh_pkg::OP_SENT && !hit_any) begin
				slot_vld_q[next_q] <= 1'b1;
				next_q             <= next_inc;
			end
			if (advance && op == rtlh_pkg::OP_ACK && hit_any) begin
				slot_vld_q[hit_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= operation;
			num_s1 <= msg_number;
			now_s1 <= now_time;
		end
		if (advance && op == rtlh_pkg::OP_SENT) begin
			if (hit_any) begin
				slot_time_q[hit_idx] <= now_s1;
			end else begin
				slot_num_q[next_q]  <= num_s1;
				slot_time_q[next_q] <= now_s1;
			end
		end
	end

endmodule

### src/rtlh_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlh_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module rtlh_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  rtlh_pkg::cmd_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output rtlh_pkg::cmd_t  pop_data
);

	rtlh_pkg::cmd_t               mem_q [rtlh_pkg::QDEPTH];
	logic [rtlh_pkg::Q_AW-1:0]    wr_ptr_q;
	logic [rtlh_pkg::Q_AW-1:0]    rd_ptr_q;
	logic [rtlh_pkg::QCNT_W-1:0]  cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign push_ready = (cnt_q != rtlh_pkg::QCNT_W'(rtlh_pkg::QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == rtlh_pkg::Q_AW'(rtlh_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == rtlh_pkg::Q_AW'(rtlh_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### src/rtlh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlh_back
// Bins round-trip times, keeps the histogram and drives the result beats.
// ----------------------------------------------------------------------------
module rtlh_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rtlh_pkg::cmd_t               cmd,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  rtlh_pkg::limits_t            limits,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         matched,
	output logic [rtlh_pkg::BKT_W-1:0]   bucket,
	output logic [rtlh_pkg::TIME_W-1:0]  elapsed,
	output logic [rtlh_pkg::CNT_W-1:0]   count,
	output logic                         last
);

	rtlh_pkg::bk_state_t          state_q;
	rtlh_pkg::bk_state_t          state_nxt;
	logic [rtlh_pkg::BKT_W-1:0]   rd_idx_q;
	logic [rtlh_pkg::CNT_W-1:0]   cnt_q [rtlh_pkg::NBUCKETS];

	logic                         out_v_q;
	logic                         matched_q;
	logic [rtlh_pkg::BKT_W-1:0]   bucket_q;
	logic [rtlh_pkg::TIME_W-1:0]  elapsed_q;
	logic [rtlh_pkg::CNT_W-1:0]   count_q;
	logic                         last_q;

	logic                         load;
	logic [rtlh_pkg::BKT_W-1:0]   pick;
	logic                         emit_v;
	logic                         emit_matched;
	logic [rtlh_pkg::BKT_W-1:0]   emit_bucket;
	logic [rtlh_pkg::TIME_W-1:0]  emit_elapsed;
	logic [rtlh_pkg::CNT_W-1:0]   emit_count;
	logic                         emit_last;
	logic                         inc_en;
	logic                         clr_en;

	assign load = !out_v_q || out_ready;

	// First limit that the elapsed time is below decides the bucket
	always_comb begin
		pick = rtlh_pkg::BKT_W'(rtlh_pkg::NLIMITS);
		for (int i = rtlh_pkg::NLIMITS - 1; i >= 0; i--) begin
			if (cmd.elapsed < limits[i]) begin
				pick = rtlh_pkg::BKT_W'(i);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rtlh_pkg::BK_IDLE: begin
				if (cmd_valid && load && cmd.op == rtlh_pkg::OP_READ) begin
					state_nxt = rtlh_pkg::BK_READ;
				end
			end
			rtlh_pkg::BK_READ: begin
				if (load && rd_idx_q == rtlh_pkg::LAST_BUCKET) begin
					state_nxt = rtlh_pkg::BK_IDLE;
				end
			end
			default: state_nxt = rtlh_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready    = 1'b0;
		emit_v       = 1'b0;
		emit_matched = 1'b0;
		emit_bucket  = '0;
		emit_elapsed = '0;
		emit_count   = '0;
		emit_last    = 1'b1;
		inc_en       = 1'b0;
		clr_en       = 1'b0;
		unique case (state_q)
			rtlh_pkg::BK_IDLE: begin
				cmd_ready = load;
				if (cmd_valid && load) begin
					unique case (cmd.op)
						rtlh_pkg::OP_SENT: begin
							emit_v       = 1'b1;
							emit_matched = cmd.matched;
						end
						rtlh_pkg::OP_ACK: begin
							emit_v       = 1'b1;
							emit_matched = cmd.matched;
							if (cmd.matched) begin
								emit_bucket  = pick;
								emit_elapsed = cmd.elapsed;
								inc_en       = 1'b1;
							end
						end
						default: emit_v = 1'b0;
					endcase
				end
			end
			rtlh_pkg::BK_READ: begin
				if (load) begin
					emit_v      = 1'b1;
					emit_bucket = rd_idx_q;
					emit_count  = cnt_q[rd_idx_q];
					emit_last   = (rd_idx_q == rtlh_pkg::LAST_BUCKET);
					clr_en      = 1'b1;
				end
			end
			default: emit_v = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rtlh_pkg::BK_IDLE;
			rd_idx_q <= '0;
			out_v_q  <= 1'b0;
			for (int i = 0; i < rtlh_pkg::NBUCKETS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (clr_en) begin
				rd_idx_q <= (rd_idx_q == rtlh_pkg::LAST_BUCKET) ? '0 : rd_idx_q + 1'b1;
			end
			if (load) begin
				out_v_q <= emit_v;
			end
			for (int i = 0; i < rtlh_pkg::NBUCKETS; i++) begin
				if (clr_en && rd_idx_q == rtlh_pkg::BKT_W'(i)) begin
					cnt_q[i] <= '0;
				end else if (inc_en && pick == rtlh_pkg::BKT_W'(i)) begin
					cnt_q[i] <= cnt_q[i] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && emit_v) begin
			matched_q <= emit_matched;
			bucket_q  <= emit_bucket;
			elapsed_q <= emit_elapsed;
			count_q   <= emit_count;
			last_q    <= emit_last;
		end
	end

	assign out_valid = out_v_q;
	assign matched   = matched_q;
	assign bucket    = bucket_q;
	assign elapsed   = elapsed_q;
	assign count     = count_q;
	assign last      = last_q;

endmodule

### src/round_trip_latency_histogram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_trip_latency_histogram_unit
// Matches sent and acknowledged messages and bins their round-trip times.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event per beat: message
//   sent, acknowledgment received, or read-and-clear of the histogram.
//   Output channel (out_valid/out_ready) returns one beat per sent or ack
//   event and six beats per read, buckets 0 to 5, with last on the final beat.
//   Events with the unused operation code produce no beat.
//   A sent or ack result passes the front match stage register, the command
//   queue and the back output register on its way out.
//   Throughput: one sent or ack event per cycle when the receiver keeps up;
//   the back end takes no command while it sends the six beats of a read.
//   Front and back are split by a two-entry command queue, so the front keeps
//   matching events while the receiver stalls until the queue fills, then
//   in_ready drops. The stalled output beat holds its value.
//   Reset: all slots free, round-robin pointer and counters at zero, default
//   limits. The user writes limits via cfg_we, cfg_index and cfg_data only when
//   idle, unenforced by the block; indexes beyond the fifth are ignored.
// ----------------------------------------------------------------------------
module round_trip_latency_histogram_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rtlh_pkg::OP_W-1:0]     operation,
	input  logic [rtlh_pkg::NUM_W-1:0]    msg_number,
	input  logic [rtlh_pkg::TIME_W-1:0]   now_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          matched,
	output logic [rtlh_pkg::BKT_W-1:0]    bucket,
	output logic [rtlh_pkg::TIME_W-1:0]   elapsed,
	output logic [rtlh_pkg::CNT_W-1:0]    count,
	output logic                          last,
	input  logic                          cfg_we,
	input  logic [rtlh_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [rtlh_pkg::CFG_DW-1:0]   cfg_data
);

	rtlh_pkg::limits_t  limits_q;
	rtlh_pkg::cmd_t     front_cmd;
	logic               front_valid;
	logic               front_ready;
	rtlh_pkg::cmd_t     back_cmd;
	logic               back_valid;
	logic               back_ready;

	// Limit registers: write on enable, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q[0] <= rtlh_pkg::LIMIT_FIRST_RST;
			limits_q[1] <= rtlh_pkg::LIMIT_SECOND_RST;
			limits_q[2] <= rtlh_pkg::LIMIT_THIRD_RST;
			limits_q[3] <= rtlh_pkg::LIMIT_FOURTH_RST;
			limits_q[4] <= rtlh_pkg::LIMIT_FIFTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtlh_pkg::CFG_LIMIT_FIRST:  limits_q[0] <= cfg_data;
				rtlh_pkg::CFG_LIMIT_SECOND: limits_q[1] <= cfg_data;
				rtlh_pkg::CFG_LIMIT_THIRD:  limits_q[2] <= cfg_data;
				rtlh_pkg::CFG_LIMIT_FOURTH: limits_q[3] <= cfg_data;
				rtlh_pkg::CFG_LIMIT_FIFTH:  limits_q[4] <= cfg_data;
				default: limits_q <= limits_q;
			endcase
		end
	end

	// Front: match against the slot table and classify
	rtlh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.msg_number (msg_number),
		.now_time   (now_time),
		.cmd        (front_cmd),
		.cmd_valid  (front_valid),
		.cmd_ready  (front_ready)
	);

	// Decouple front from a stalled back end
	rtlh_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_cmd)
	);

	// Back: histogram update and result beats
	rtlh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (back_cmd),
		.cmd_valid  (back_valid),
		.cmd_ready  (back_ready),
		.limits     (limits_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.matched    (matched),
		.bucket     (bucket),
		.elapsed    (elapsed),
		.count      (count),
		.last       (last)
	);

endmodule

### src/rtlh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlh_checker
// Port-level checks of the round-trip latency histogram.
// ----------------------------------------------------------------------------
module rtlh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          matched,
	input logic [rtlh_pkg::BKT_W-1:0]    bucket,
	input logic [rtlh_pkg::TIME_W-1:0]   elapsed,
	input logic [rtlh_pkg::CNT_W-1:0]    count,
	input logic                          last
);

	// Stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(matched) && $stable(bucket)
			&& $stable(elapsed) && $stable(count) && $stable(last))
		else $error("stalled result beat changed");

	// Only histogram reads give beats without last, and never for the top bucket
	a_nonlast_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !matched && elapsed == '0 && bucket != rtlh_pkg::LAST_BUCKET)
		else $error("non-final beat is not a histogram read");

	// A matched event never carries a count
	a_match_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && matched |-> count == '0 && last)
		else $error("matched beat carries a count");

	// Read beats follow each other back to back in bucket order
	a_read_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid
			&& bucket == $past(bucket) + 1'b1)
		else $error("histogram read beats out of order");

endmodule

bind round_trip_latency_histogram_unit rtlh_checker u_rtlh_checker (.*);
